// File: design/i2c_master_transaction_engine_macros.svh
// Assertion macros for the I2C master transaction engine.
// Used by the top level only; needs a clock i_clk and a reset i_rst_n in scope.
`ifndef I2C_MASTER_TRANSACTION_ENGINE_MACROS_SVH
`define I2C_MASTER_TRANSACTION_ENGINE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define I2CM_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define I2CM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// File: design/i2cm_pkg.sv
// Shared types, constants and phase-step functions of the I2C master engine.
// No dependencies; used by i2cm_wbuf, i2cm_core and the top level.
`default_nettype none

package i2cm_pkg;

    localparam int BUFFER_DEPTH_DEF = 128;

    // Configuration register indexes.
    localparam logic [2:0] CFG_SLAVE_ADDRESS   = 3'd0;
    localparam logic [2:0] CFG_HOLD_TICKS      = 3'd1;
    localparam logic [2:0] CFG_ADDR_ACK_WAIT   = 3'd2;
    localparam logic [2:0] CFG_BYTE_ACK_WAIT   = 3'd3;
    localparam logic [2:0] CFG_ADDR_RETRIES    = 3'd4;

    localparam logic [6:0]  SLAVE_ADDRESS_RST  = 7'd48;
    localparam logic [7:0]  HOLD_TICKS_RST     = 8'd1;
    localparam logic [11:0] ADDR_ACK_WAIT_RST  = 12'd550;
    localparam logic [7:0]  BYTE_ACK_WAIT_RST  = 8'd8;
    localparam logic [2:0]  ADDR_RETRIES_RST   = 3'd3;

    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_WRITE = 2'd1,
        OP_READ  = 2'd2,
        OP_LOAD  = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        STAT_NONE = 2'd0,
        STAT_DONE = 2'd1,
        STAT_NACK = 2'd2
    } t_status;

    typedef enum logic [23:0] {
        P_IDLE = 24'h000001,
        P_ST0  = 24'h000002,
        P_ST1  = 24'h000004,
        P_ST2  = 24'h000008,
        P_ST3  = 24'h000010,
        P_WB0  = 24'h000020,
        P_WB1  = 24'h000040,
        P_WB2  = 24'h000080,
        P_GA0  = 24'h000100,
        P_GA1  = 24'h000200,
        P_GA2  = 24'h000400,
        P_GA3  = 24'h000800,
        P_RB0  = 24'h001000,
        P_RB1  = 24'h002000,
        P_RB2  = 24'h004000,
        P_RB3  = 24'h008000,
        P_RB4  = 24'h010000,
        P_MA0  = 24'h020000,
        P_MA1  = 24'h040000,
        P_MA2  = 24'h080000,
        P_MA3  = 24'h100000,
        P_SP0  = 24'h200000,
        P_SP1  = 24'h400000,
        P_SP2  = 24'h800000
    } t_phase;

    typedef struct packed {
        logic [6:0]  slave_address;
        logic [7:0]  hold_ticks;
        logic [11:0] address_ack_wait;
        logic [7:0]  byte_ack_wait;
        logic [2:0]  address_retries;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        slave_address:    SLAVE_ADDRESS_RST,
        hold_ticks:       HOLD_TICKS_RST,
        address_ack_wait: ADDR_ACK_WAIT_RST,
        byte_ack_wait:    BYTE_ACK_WAIT_RST,
        address_retries:  ADDR_RETRIES_RST
    };

    // Engine state plus the per-transaction result flags.
    typedef struct packed {
        t_phase      phase;
        logic [11:0] tick_count;
        logic [3:0]  bit_index;
        logic [7:0]  byte_index;
        logic [7:0]  byte_total;
        logic [7:0]  shift_reg;
        logic [2:0]  attempt_count;
        logic        is_read;
        logic        scl_level;
        logic        sda_level;
        logic        sda_dir;
        logic        addr_stage;
        logic        ack_missed;
        logic [7:0]  res_byte;
        logic        res_valid;
        t_status     res_status;
        logic        clr_load;
    } t_state;

    localparam t_state STATE_RESET = '{
        phase:         P_IDLE,
        tick_count:    12'd0,
        bit_index:     4'd0,
        byte_index:    8'd0,
        byte_total:    8'd0,
        shift_reg:     8'd0,
        attempt_count: 3'd0,
        is_read:       1'b0,
        scl_level:     1'b1,
        sda_level:     1'b1,
        sda_dir:       1'b0,
        addr_stage:    1'b0,
        ack_missed:    1'b0,
        res_byte:      8'd0,
        res_valid:     1'b0,
        res_status:    STAT_NONE,
        clr_load:      1'b0
    };

    typedef struct packed {
        logic       scl;
        logic       sda_out;
        logic       sda_drive;
        logic [7:0] read_byte;
        logic       read_valid;
        logic       busy;
        t_status    status;
    } t_result;

    // A zero hold is treated as a hold of one tick.
    function automatic logic [11:0] hold_len(input t_cfg c);
        logic [11:0] w;
        w = {4'd0, c.hold_ticks};
        if (c.hold_ticks == 8'd0) begin
            w = 12'd1;
        end
        return w;
    endfunction

    // Moves to phase p, performs its pin action and loads its wait.
    function automatic t_state enter_phase(input t_state s, input t_phase p, input t_cfg c);
        t_state      n;
        logic [11:0] w;
        n = s;
        w = hold_len(c);
        n.phase = p;
        case (p)
            P_ST0: begin
                n.sda_dir   = 1'b1;
                n.sda_level = 1'b1;
            end
            P_ST1, P_WB1, P_GA1, P_RB2, P_MA1, P_SP1: begin
                n.scl_level = 1'b1;
            end
            P_ST2: begin
                n.sda_level = 1'b0;
            end
            P_ST3, P_WB2, P_GA2, P_RB1, P_RB4, P_MA2: begin
                n.scl_level = 1'b0;
            end
            P_WB0: begin
                n.sda_dir   = 1'b1;
                n.sda_level = s.shift_reg[7];
            end
            P_GA0: begin
                n.sda_level = 1'b0;
                n.sda_dir   = 1'b0;
            end
            P_GA3: begin
                w = s.addr_stage ? c.address_ack_wait : {4'd0, c.byte_ack_wait};
            end
            P_RB0: begin
                n.scl_level = 1'b0;
                n.sda_dir   = 1'b0;
            end
            P_MA0: begin
                n.sda_dir   = 1'b1;
                n.sda_level = (({1'b0, s.byte_index} + 9'd1) >= {1'b0, s.byte_total});
            end
            P_MA3: begin
                w = {4'd0, c.byte_ack_wait};
            end
            P_SP0: begin
                n.sda_dir   = 1'b1;
                n.sda_level = 1'b0;
            end
            P_SP2: begin
                n.sda_level = 1'b1;
            end
            default: begin
            end
        endcase
        n.tick_count = w;
        return n;
    endfunction

    function automatic t_state start_write(input t_state s, input t_cfg c,
                                           input logic [7:0] fetch);
        t_state n;
        n = s;
        n.shift_reg = fetch;
        n.bit_index = 4'd0;
        return enter_phase(n, P_WB0, c);
    endfunction

    function automatic t_state after_payload(input t_state s, input t_cfg c,
                                             input logic [7:0] fetch);
        t_state n;
        n = s;
        n.byte_index = s.byte_index + 8'd1;
        if (n.byte_index >= n.byte_total) begin
            n = enter_phase(n, P_SP0, c);
        end else if (n.is_read) begin
            n = enter_phase(n, P_RB0, c);
        end else begin
            n = start_write(n, c, fetch);
        end
        return n;
    endfunction

    // Ends the current phase and moves on; fetch is the next write byte.
    function automatic t_state leave_step(input t_state s, input logic sda, input t_cfg c,
                                          input logic [7:0] fetch);
        t_state n;
        n = s;
        case (s.phase)
            P_ST3: begin
                n.shift_reg = {c.slave_address, s.is_read};
                n.bit_index = 4'd0;
                n = enter_phase(n, P_WB0, c);
            end
            P_WB2: begin
                n.shift_reg = {s.shift_reg[6:0], 1'b0};
                n.bit_index = s.bit_index + 4'd1;
                n = enter_phase(n, (n.bit_index < 4'd8) ? P_WB0 : P_GA0, c);
            end
            P_GA1: begin
                n.ack_missed = sda;
                n = enter_phase(n, P_GA2, c);
            end
            P_GA3: begin
                if (!s.addr_stage) begin
                    n = after_payload(n, c, fetch);
                end else if (s.ack_missed) begin
                    if (s.attempt_count < c.address_retries) begin
                        n.attempt_count = s.attempt_count + 3'd1;
                        n = enter_phase(n, P_ST0, c);
                    end else begin
                        n = enter_phase(n, P_SP0, c);
                    end
                end else begin
                    n.addr_stage = 1'b0;
                    n.byte_index = 8'd0;
                    if (s.byte_total == 8'd0) begin
                        n = enter_phase(n, P_SP0, c);
                    end else if (s.is_read) begin
                        n = enter_phase(n, P_RB0, c);
                    end else begin
                        n = start_write(n, c, fetch);
                    end
                end
            end
            P_RB0: begin
                n.bit_index = 4'd0;
                n.shift_reg = 8'd0;
                n = enter_phase(n, P_RB1, c);
            end
            P_RB2: begin
                n.shift_reg = {s.shift_reg[6:0], sda};
                n.bit_index = s.bit_index + 4'd1;
                if (n.bit_index >= 4'd8) begin
                    n.res_byte  = n.shift_reg;
                    n.res_valid = 1'b1;
                end
                n = enter_phase(n, P_RB3, c);
            end
            P_RB4: begin
                n = enter_phase(n, (s.bit_index < 4'd8) ? P_RB1 : P_MA0, c);
            end
            P_MA3: begin
                n = after_payload(n, c, fetch);
            end
            P_SP2: begin
                n.res_status = (s.addr_stage && s.ack_missed) ? STAT_NACK : STAT_DONE;
                n.clr_load   = !s.is_read;
                n.phase      = P_IDLE;
                n.tick_count = 12'd0;
            end
            P_ST0: n = enter_phase(n, P_ST1, c);
            P_ST1: n = enter_phase(n, P_ST2, c);
            P_ST2: n = enter_phase(n, P_ST3, c);
            P_WB0: n = enter_phase(n, P_WB1, c);
            P_WB1: n = enter_phase(n, P_WB2, c);
            P_GA0: n = enter_phase(n, P_GA1, c);
            P_GA2: n = enter_phase(n, P_GA3, c);
            P_RB1: n = enter_phase(n, P_RB2, c);
            P_RB3: n = enter_phase(n, P_RB4, c);
            P_MA0: n = enter_phase(n, P_MA1, c);
            P_MA1: n = enter_phase(n, P_MA2, c);
            P_MA2: n = enter_phase(n, P_MA3, c);
            P_SP0: n = enter_phase(n, P_SP1, c);
            P_SP1: n = enter_phase(n, P_SP2, c);
            default: begin
                n.phase      = P_IDLE;
                n.tick_count = 12'd0;
            end
        endcase
        return n;
    endfunction

endpackage

`default_nettype wire

// File: design/i2cm_wbuf.sv
// Write buffer memory: one write port and one read port with registered data.
// Depends on i2cm_pkg for the default depth.
`default_nettype none

module i2cm_wbuf #(
    parameter int  DEPTH = i2cm_pkg::BUFFER_DEPTH_DEF,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic          i_clk,
    input  wire logic          i_wr_en,
    input  wire logic [AW-1:0] i_wr_addr,
    input  wire logic [7:0]    i_wr_data,
    input  wire logic [AW-1:0] i_rd_addr,
    output logic      [7:0]    o_rd_data
);

    logic [7:0] r_mem [DEPTH];
    logic [7:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

// File: design/i2cm_core.sv
// Phase sequencer of the I2C master: state registers, loaded-byte count and
// buffer addressing. Depends on i2cm_pkg; reads the buffer held in i2cm_wbuf.
`default_nettype none

module i2cm_core #(
    parameter int  DEPTH = i2cm_pkg::BUFFER_DEPTH_DEF,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int LCW   = $clog2(DEPTH + 1)
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire i2cm_pkg::t_cfg    i_cfg,
    input  wire logic              i_accept,
    input  wire logic [1:0]        i_operation,
    input  wire logic [7:0]        i_byte_count,
    input  wire logic [7:0]        i_write_byte,
    input  wire logic              i_sda_sample,
    input  wire logic [7:0]        i_rd_data,
    output logic      [AW-1:0]     o_rd_addr,
    output logic                   o_wr_en,
    output logic      [AW-1:0]     o_wr_addr,
    output logic      [7:0]        o_wr_data,
    output i2cm_pkg::t_result      o_res
);

    localparam logic [8:0]     DEPTH_W = 9'(DEPTH);
    localparam logic [LCW-1:0] DEPTH_L = LCW'(DEPTH);

    i2cm_pkg::t_state r_st;
    i2cm_pkg::t_state n_st;
    i2cm_pkg::t_state s_one;
    i2cm_pkg::t_state s_two;
    logic [LCW-1:0]   r_load_count;
    logic [LCW-1:0]   n_load_count;
    logic [8:0]       fetch_idx;
    logic [7:0]       fetch_byte;
    logic             load_ok;
    i2cm_pkg::t_op    op;

    assign op = i2cm_pkg::t_op'(i_operation);

    // The byte that the next write-byte start needs is prefetched all the time:
    // byte zero during the address stage, else the one after the current byte.
    assign fetch_idx  = r_st.addr_stage ? 9'd0 : ({1'b0, r_st.byte_index} + 9'd1);
    assign o_rd_addr  = (fetch_idx < DEPTH_W) ? fetch_idx[AW-1:0] : '0;
    assign fetch_byte = (fetch_idx < 9'(r_load_count)) ? i_rd_data : 8'd0;

    assign load_ok   = (r_load_count < DEPTH_L);
    assign o_wr_addr = r_load_count[AW-1:0];
    assign o_wr_data = i_write_byte;

    always_comb begin
        n_st            = r_st;
        n_st.res_byte   = 8'd0;
        n_st.res_valid  = 1'b0;
        n_st.res_status = i2cm_pkg::STAT_NONE;
        n_st.clr_load   = 1'b0;
        n_load_count    = r_load_count;
        o_wr_en         = 1'b0;
        s_one           = n_st;
        s_two           = n_st;
        if (r_st.phase == i2cm_pkg::P_IDLE) begin
            if ((op inside {i2cm_pkg::OP_WRITE, i2cm_pkg::OP_READ})
                    && ({1'b0, i_byte_count} <= DEPTH_W)) begin
                n_st.is_read       = (op == i2cm_pkg::OP_READ);
                n_st.byte_total    = i_byte_count;
                n_st.byte_index    = 8'd0;
                n_st.bit_index     = 4'd0;
                n_st.attempt_count = 3'd0;
                n_st.addr_stage    = 1'b1;
                n_st.ack_missed    = 1'b0;
                n_st = i2cm_pkg::enter_phase(n_st, i2cm_pkg::P_ST0, i_cfg);
            end else if ((op == i2cm_pkg::OP_LOAD) && load_ok) begin
                o_wr_en      = i_accept;
                n_load_count = r_load_count + LCW'(1);
            end
        end else if (op == i2cm_pkg::OP_TICK) begin
            if (r_st.tick_count > 12'd1) begin
                n_st.tick_count = r_st.tick_count - 12'd1;
            end else begin
                // Only the acknowledge-wait phases can carry a zero wait, and the
                // phase after them never does, so two steps cover every case.
                s_one = i2cm_pkg::leave_step(n_st, i_sda_sample, i_cfg, fetch_byte);
                s_two = s_one;
                if ((s_one.phase != i2cm_pkg::P_IDLE) && (s_one.tick_count == 12'd0)) begin
                    s_two = i2cm_pkg::leave_step(s_one, i_sda_sample, i_cfg, fetch_byte);
                end
                n_st = s_two;
            end
        end
        if (n_st.clr_load) begin
            n_load_count = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st         <= i2cm_pkg::STATE_RESET;
            r_load_count <= '0;
        end else if (i_accept) begin
            r_st         <= n_st;
            r_load_count <= n_load_count;
        end
    end

    always_comb begin
        o_res.scl        = n_st.scl_level;
        o_res.sda_out    = n_st.sda_dir & n_st.sda_level;
        o_res.sda_drive  = n_st.sda_dir;
        o_res.read_byte  = n_st.res_byte;
        o_res.read_valid = n_st.res_valid;
        o_res.busy       = (n_st.phase != i2cm_pkg::P_IDLE);
        o_res.status     = n_st.res_status;
    end

endmodule

`default_nettype wire

// File: design/i2c_master_transaction_engine.sv
// Top level of the I2C master transaction engine: configuration registers,
// output register and handshake. Depends on i2cm_pkg, i2cm_wbuf, i2cm_core
// and the assertion macros header.
//
//   Channel   Direction  Handshake                 Carries
//   in        input      i_in_valid / o_in_ready   operation, byte count, write byte, SDA
//   out       output     o_out_valid / i_out_ready pin levels, read byte, busy, status
//   cfg       input      i_cfg_we (no wait)        register index and data
//
// One transaction is taken in every clock cycle and its result appears in the
// output register on the next cycle. Within that cycle the sequencer may end
// two phases back to back, which sets the longest path; write bytes come from a
// prefetched read of the buffer memory, so its registered output adds no delay.
// Reset is synchronous and active low; the buffer memory needs no clearing
// pass. When the output register is full and not taken, the input stalls.
`default_nettype none

`include "i2c_master_transaction_engine_macros.svh"

module i2c_master_transaction_engine #(
    parameter int  BUFFER_DEPTH = i2cm_pkg::BUFFER_DEPTH_DEF,
    localparam int AW           = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // input transactions
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [1:0]  i_operation,
    input  wire logic [7:0]  i_byte_count,
    input  wire logic [7:0]  i_write_byte,
    input  wire logic        i_sda_sample,
    // result transactions
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic             o_scl,
    output logic             o_sda_out,
    output logic             o_sda_drive,
    output logic [7:0]       o_read_byte,
    output logic             o_read_valid,
    output logic             o_busy_res,
    output logic [1:0]       o_status,
    // configuration writes
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [11:0] i_cfg_data
);

    i2cm_pkg::t_cfg    r_cfg;
    i2cm_pkg::t_result r_res;
    i2cm_pkg::t_result core_res;
    logic              r_out_valid;
    logic              accept;
    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    logic [7:0]        wr_data;
    logic [AW-1:0]     rd_addr;
    logic [7:0]        rd_data;

    // A new transaction is taken whenever the output register is empty or is
    // being emptied in the same cycle.
    assign o_in_ready = !r_out_valid || i_out_ready;
    assign accept     = i_in_valid && o_in_ready;

    // Configuration registers. The user must write only while the engine is idle; not enforced.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= i2cm_pkg::CFG_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                i2cm_pkg::CFG_SLAVE_ADDRESS: r_cfg.slave_address    <= i_cfg_data[6:0];
                i2cm_pkg::CFG_HOLD_TICKS:    r_cfg.hold_ticks       <= i_cfg_data[7:0];
                i2cm_pkg::CFG_ADDR_ACK_WAIT: r_cfg.address_ack_wait <= i_cfg_data;
                i2cm_pkg::CFG_BYTE_ACK_WAIT: r_cfg.byte_ack_wait    <= i_cfg_data[7:0];
                i2cm_pkg::CFG_ADDR_RETRIES:  r_cfg.address_retries  <= i_cfg_data[2:0];
                default: begin
                end
            endcase
        end
    end

    i2cm_wbuf #(
        .DEPTH (BUFFER_DEPTH)
    ) u_wbuf (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    i2cm_core #(
        .DEPTH (BUFFER_DEPTH)
    ) u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_accept     (accept),
        .i_operation  (i_operation),
        .i_byte_count (i_byte_count),
        .i_write_byte (i_write_byte),
        .i_sda_sample (i_sda_sample),
        .i_rd_data    (rd_data),
        .o_rd_addr    (rd_addr),
        .o_wr_en      (wr_en),
        .o_wr_addr    (wr_addr),
        .o_wr_data    (wr_data),
        .o_res        (core_res)
    );

    // Output register: the valid flag is control state, the payload is not reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_res <= core_res;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_scl        = r_res.scl;
    assign o_sda_out    = r_res.sda_out;
    assign o_sda_drive  = r_res.sda_drive;
    assign o_read_byte  = r_res.read_byte;
    assign o_read_valid = r_res.read_valid;
    assign o_busy_res   = r_res.busy;
    assign o_status     = r_res.status;

    // A received byte can only appear while a transfer is still running.
    `I2CM_ASSERT_NOW(a_read_while_busy, o_out_valid && o_read_valid, o_busy_res, "read byte outside a transfer")
    // A completion status is only reported once the engine has gone idle.
    `I2CM_ASSERT_NOW(a_status_idle, o_out_valid && (o_status != i2cm_pkg::STAT_NONE), !o_busy_res, "status while busy")
    // Between transfers the bus clock rests high.
    `I2CM_ASSERT_NOW(a_idle_scl_high, o_out_valid && !o_busy_res, o_scl, "SCL low while idle")
    // Every accepted transaction fills the output register.
    `I2CM_ASSERT_NEXT(a_accept_fills, accept, o_out_valid, "accepted transaction lost")

endmodule

`default_nettype wire

// File: test/tb_i2c_master_transaction_engine.sv
// Self-checking testbench for the I2C master transaction engine: a driver and a monitor
// as clocked processes, with a cycle-accurate bus predictor run on every accepted item.
// Depends on i2cm_pkg and the i2c_master_transaction_engine top level.

module tb_i2c_master_transaction_engine;

    timeunit 1ns;
    timeprecision 1ps;

    import i2cm_pkg::*;

    localparam int BUF_DEPTH     = BUFFER_DEPTH_DEF;
    // Quiet cycles allowed before the run is declared hung. The longest correct quiet
    // stretch is a drain followed by the five register writes, or two stall bursts back
    // to back, so this is many times more than any correct run needs.
    localparam int QUIET_LIMIT   = 4000;
    // Bus-advancing items wanted from the random part.
    localparam int RANDOM_WORK   = 360;
    // Bus-advancing items at the end of the random part that run with no idling.
    localparam int CALM_WORK     = 120;

    // One item offered on the input channel.
    typedef struct packed {
        t_op        op;
        logic [7:0] count;
        logic [7:0] data;
        logic       sda;
    } bus_op_t;

    // Bus engine state as the predictor tracks it, plus what the current item reports.
    typedef struct packed {
        t_phase      ph;
        logic [11:0] ticks;
        logic [3:0]  bit_n;
        logic [7:0]  byte_n;
        logic [7:0]  byte_cnt;
        logic [7:0]  shreg;
        logic [2:0]  tries;
        logic        rd;
        logic [7:0]  loaded;
        logic        scl;
        logic        sda;
        logic        drv;
        logic        in_addr;
        logic        missed;
        logic [7:0]  got_byte;
        logic        got_valid;
        t_status     stat;
    } bus_state_t;

    logic        i_clk        = 1'b0;
    logic        i_rst_n      = 1'b0;
    logic        i_in_valid   = 1'b0;
    logic        o_in_ready;
    logic [1:0]  i_operation  = 2'd0;
    logic [7:0]  i_byte_count = 8'd0;
    logic [7:0]  i_write_byte = 8'd0;
    logic        i_sda_sample = 1'b0;
    logic        o_out_valid;
    logic        i_out_ready  = 1'b0;
    logic        o_scl;
    logic        o_sda_out;
    logic        o_sda_drive;
    logic [7:0]  o_read_byte;
    logic        o_read_valid;
    logic        o_busy_res;
    logic [1:0]  o_status;
    logic        i_cfg_we     = 1'b0;
    logic [2:0]  i_cfg_index  = 3'd0;
    logic [11:0] i_cfg_data   = 12'd0;

    i2c_master_transaction_engine dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_operation  (i_operation),
        .i_byte_count (i_byte_count),
        .i_write_byte (i_write_byte),
        .i_sda_sample (i_sda_sample),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_scl        (o_scl),
        .o_sda_out    (o_sda_out),
        .o_sda_drive  (o_sda_drive),
        .o_read_byte  (o_read_byte),
        .o_read_valid (o_read_valid),
        .o_busy_res   (o_busy_res),
        .o_status     (o_status),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    always #1 i_clk = ~i_clk;

    // Register settings as the engine currently holds them.
    t_cfg       eng_cfg;
    // The write buffer as the checking predictor sees it.
    logic [7:0] wr_mem [BUF_DEPTH];
    // Two copies of the bus state: gen_state runs ahead as items are queued, so that the
    // stimulus knows where an acknowledge will be sampled and when a transfer has ended;
    // chk_state advances only when the block accepts an item and yields the expectation.
    bus_state_t gen_state;
    bus_state_t chk_state;

    bus_op_t    pending_ops [$];
    t_result    predicted_results [$];
    bus_op_t    on_bus;

    int ops_queued   = 0;
    int ops_taken    = 0;
    int random_work  = 0;
    int results_seen = 0;
    int mismatches   = 0;
    int stray        = 0;
    int done_seen    = 0;
    int nack_seen    = 0;
    int bytes_seen   = 0;
    int idle_pct     = 10;
    int gap_left     = 0;
    int stall_left   = 0;
    int quiet        = 0;

    // ------------------------------------------------------------------
    // Bus predictor
    // ------------------------------------------------------------------

    function automatic bus_state_t fresh_state();
        bus_state_t s;
        s      = '0;
        s.ph   = P_IDLE;
        s.scl  = 1'b1;
        s.sda  = 1'b1;
        s.stat = STAT_NONE;
        return s;
    endfunction

    // Enters a phase: performs its pin action and loads the number of ticks it lasts.
    function automatic void go_phase(inout bus_state_t s, input t_phase p);
        logic [11:0] w;
        // A zero hold still lasts one tick.
        w    = (eng_cfg.hold_ticks == 8'd0) ? 12'd1 : {4'd0, eng_cfg.hold_ticks};
        s.ph = p;
        case (p)
            P_ST0: begin
                s.drv = 1'b1;
                s.sda = 1'b1;
            end
            P_ST1, P_WB1, P_GA1, P_RB2, P_MA1, P_SP1: s.scl = 1'b1;
            P_ST2: s.sda = 1'b0;
            P_ST3, P_WB2, P_GA2, P_RB1, P_RB4, P_MA2: s.scl = 1'b0;
            P_WB0: begin
                s.drv = 1'b1;
                s.sda = s.shreg[7];
            end
            P_GA0: begin
                s.sda = 1'b0;
                s.drv = 1'b0;
            end
            P_GA3: w = s.in_addr ? eng_cfg.address_ack_wait : {4'd0, eng_cfg.byte_ack_wait};
            P_RB0: begin
                s.scl = 1'b0;
                s.drv = 1'b0;
            end
            P_MA0: begin
                // Acknowledge every byte but the last, which is not acknowledged.
                s.drv = 1'b1;
                s.sda = ({1'b0, s.byte_n} + 9'd1) >= {1'b0, s.byte_cnt};
            end
            P_MA3: w = {4'd0, eng_cfg.byte_ack_wait};
            P_SP0: begin
                s.drv = 1'b1;
                s.sda = 1'b0;
            end
            P_SP2: s.sda = 1'b1;
            default: begin
            end
        endcase
        s.ticks = w;
    endfunction

    // Loads the next payload byte; positions that were never loaded go out as zero.
    function automatic void send_next_byte(inout bus_state_t s);
        s.shreg = (s.byte_n < s.loaded) ? wr_mem[s.byte_n[6:0]] : 8'h00;
        s.bit_n = 4'd0;
        go_phase(s, P_WB0);
    endfunction

    function automatic void next_payload(inout bus_state_t s);
        s.byte_n = s.byte_n + 8'd1;
        if (s.byte_n >= s.byte_cnt) begin
            go_phase(s, P_SP0);
        end else if (s.rd) begin
            go_phase(s, P_RB0);
        end else begin
            send_next_byte(s);
        end
    endfunction

    // Ends the current phase, sampling SDA where an SCL-high phase closes.
    function automatic void end_phase(inout bus_state_t s, input logic sda_in);
        case (s.ph)
            P_ST3: begin
                s.shreg = {eng_cfg.slave_address, s.rd};
                s.bit_n = 4'd0;
                go_phase(s, P_WB0);
            end
            P_WB2: begin
                s.shreg = {s.shreg[6:0], 1'b0};
                s.bit_n = s.bit_n + 4'd1;
                go_phase(s, (s.bit_n < 4'd8) ? P_WB0 : P_GA0);
            end
            P_GA1: begin
                s.missed = sda_in;
                go_phase(s, P_GA2);
            end
            P_GA3: begin
                if (!s.in_addr) begin
                    // Data byte acknowledges are ignored.
                    next_payload(s);
                end else if (s.missed) begin
                    if (s.tries < eng_cfg.address_retries) begin
                        s.tries = s.tries + 3'd1;
                        go_phase(s, P_ST0);
                    end else begin
                        go_phase(s, P_SP0);
                    end
                end else begin
                    s.in_addr = 1'b0;
                    s.byte_n  = 8'd0;
                    if (s.byte_cnt == 8'd0) begin
                        go_phase(s, P_SP0);
                    end else if (s.rd) begin
                        go_phase(s, P_RB0);
                    end else begin
                        send_next_byte(s);
                    end
                end
            end
            P_RB0: begin
                s.bit_n = 4'd0;
                s.shreg = 8'd0;
                go_phase(s, P_RB1);
            end
            P_RB2: begin
                s.shreg = {s.shreg[6:0], sda_in};
                s.bit_n = s.bit_n + 4'd1;
                if (s.bit_n >= 4'd8) begin
                    s.got_byte  = s.shreg;
                    s.got_valid = 1'b1;
                end
                go_phase(s, P_RB3);
            end
            P_RB4: go_phase(s, (s.bit_n < 4'd8) ? P_RB1 : P_MA0);
            P_MA3: next_payload(s);
            P_SP2: begin
                s.stat = (s.in_addr && s.missed) ? STAT_NACK : STAT_DONE;
                // A finished write frees the buffer for the next one.
                if (!s.rd) begin
                    s.loaded = 8'd0;
                end
                s.ph    = P_IDLE;
                s.ticks = 12'd0;
            end
            P_IDLE: s.ticks = 12'd0;
            // Every other phase simply hands over to the one after it; the phase
            // code is one-hot, so that is the next bit up.
            default: go_phase(s, t_phase'({s.ph[22:0], 1'b0}));
        endcase
    endfunction

    // Applies one accepted item and returns the result the block must report for it.
    // Only the checking copy keeps the buffer contents.
    function automatic t_result bus_step(inout bus_state_t s, input bus_op_t it,
                                         input bit keep_data);
        t_result r;
        int      g;
        s.got_byte  = 8'd0;
        s.got_valid = 1'b0;
        s.stat      = STAT_NONE;
        if (s.ph == P_IDLE) begin
            if ((it.op == OP_WRITE || it.op == OP_READ) && it.count <= BUF_DEPTH) begin
                s.rd       = (it.op == OP_READ);
                s.byte_cnt = it.count;
                s.byte_n   = 8'd0;
                s.bit_n    = 4'd0;
                s.tries    = 3'd0;
                s.in_addr  = 1'b1;
                s.missed   = 1'b0;
                go_phase(s, P_ST0);
            end else if (it.op == OP_LOAD && s.loaded < BUF_DEPTH) begin
                if (keep_data) begin
                    wr_mem[s.loaded[6:0]] = it.data;
                end
                s.loaded = s.loaded + 8'd1;
            end
        end else if (it.op == OP_TICK) begin
            if (s.ticks > 12'd1) begin
                s.ticks = s.ticks - 12'd1;
            end else begin
                // Phases with no wait are passed through within the same tick.
                end_phase(s, it.sda);
                for (g = 0; g < 8 && s.ph != P_IDLE && s.ticks == 12'd0; g++) begin
                    end_phase(s, it.sda);
                end
            end
        end
        r.scl        = s.scl;
        r.sda_out    = s.drv & s.sda;
        r.sda_drive  = s.drv;
        r.read_byte  = s.got_byte;
        r.read_valid = s.got_valid;
        r.busy       = (s.ph != P_IDLE);
        r.status     = s.stat;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Driver: offers queued items, with random gaps, and predicts each accepted one.
    // ------------------------------------------------------------------

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                predicted_results.push_back(bus_step(chk_state, on_bus, 1'b1));
                ops_taken++;
            end
            if (!i_in_valid || o_in_ready) begin
                if (gap_left != 0) begin
                    gap_left--;
                    i_in_valid <= 1'b0;
                end else if (pending_ops.size() != 0 && idle_pct != 0
                             && $urandom_range(0, 99) < idle_pct) begin
                    // A gap that includes this cycle; gap_left counts the idle cycles after it.
                    gap_left = $urandom_range(0, 8);
                    i_in_valid <= 1'b0;
                end else if (pending_ops.size() != 0) begin
                    on_bus = pending_ops.pop_front();
                    i_operation  <= on_bus.op;
                    i_byte_count <= on_bus.count;
                    i_write_byte <= on_bus.data;
                    i_sda_sample <= on_bus.sda;
                    i_in_valid   <= 1'b1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: takes results, with random stalls, and checks each against the oldest
    // prediction.
    // ------------------------------------------------------------------

    task automatic check_field(input string what, input int unsigned want,
                               input int unsigned seen);
        if (want != seen) begin
            mismatches++;
            if (mismatches <= 10) begin
                $display("Result %0d: %s expected 0x%0h, got 0x%0h",
                         results_seen, what, want, seen);
            end
        end
    endtask

    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                results_seen++;
                if (predicted_results.size() == 0) begin
                    stray++;
                    if (stray <= 10) begin
                        $display("Result %0d arrived with nothing predicted", results_seen);
                    end
                end else begin
                    want = predicted_results.pop_front();
                    check_field("scl", 32'(want.scl), 32'(o_scl));
                    check_field("sda_out", 32'(want.sda_out), 32'(o_sda_out));
                    check_field("sda_drive", 32'(want.sda_drive), 32'(o_sda_drive));
                    check_field("read_byte", 32'(want.read_byte), 32'(o_read_byte));
                    check_field("read_valid", 32'(want.read_valid), 32'(o_read_valid));
                    check_field("busy_res", 32'(want.busy), 32'(o_busy_res));
                    check_field("status", 32'(want.status), 32'(o_status));
                    if (want.status == STAT_DONE) done_seen++;
                    if (want.status == STAT_NACK) nack_seen++;
                    if (want.read_valid) bytes_seen++;
                end
            end
            if (stall_left != 0) begin
                stall_left--;
                i_out_ready <= 1'b0;
            end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
                stall_left = $urandom_range(0, 8);
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    // Watchdog: ends the run if neither channel completes a transaction for too long.
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            quiet = 0;
        end else begin
            quiet++;
            if (quiet >= QUIET_LIMIT) begin
                $display("No transaction for %0d cycles, giving up", QUIET_LIMIT);
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------

    // Queues an item and advances the look-ahead copy of the bus state. Items that the
    // engine ignores (ticks while idle, begins and loads while busy, oversized begins,
    // loads into a full buffer) do not count as work.
    task automatic push_op(input t_op op, input logic [7:0] count, input logic [7:0] data,
                           input logic sda);
        bus_op_t    it;
        t_result    unused;
        bit         was_busy;
        logic [7:0] old_loaded;
        it         = '{op: op, count: count, data: data, sda: sda};
        was_busy   = (gen_state.ph != P_IDLE);
        old_loaded = gen_state.loaded;
        unused     = bus_step(gen_state, it, 1'b0);
        if (was_busy ? (op == OP_TICK)
                     : (gen_state.ph != P_IDLE || gen_state.loaded != old_loaded)) begin
            random_work++;
        end
        pending_ops.push_back(it);
        ops_queued++;
    endtask

    task automatic load_buffer(input int n);
        repeat (n) push_op(OP_LOAD, 8'($urandom), 8'($urandom), 1'($urandom));
    endtask

    // Runs one transfer to its end. The first forced_nacks address acknowledges are
    // refused, later ones are refused with the given chance. With noise, begins and
    // loads are slipped in while the engine is busy, where they must be ignored.
    task automatic run_transfer(input t_op op, input logic [7:0] count, input int forced_nacks,
                                input int nack_pct, input int noise_pct);
        int   nacks_left;
        logic line;
        nacks_left = forced_nacks;
        push_op(op, count, 8'($urandom), 1'($urandom));
        while (gen_state.ph != P_IDLE) begin
            if (noise_pct != 0 && $urandom_range(0, 99) < noise_pct) begin
                push_op(t_op'($urandom_range(1, 3)), 8'($urandom), 8'($urandom),
                        1'($urandom));
            end
            line = 1'($urandom_range(0, 1));
            // Only the tick that closes the address acknowledge clock decides it.
            if (gen_state.ph == P_GA1 && gen_state.in_addr && gen_state.ticks <= 12'd1) begin
                if (nacks_left > 0) begin
                    line = 1'b1;
                    nacks_left--;
                end else begin
                    line = ($urandom_range(0, 99) < nack_pct);
                end
            end
            push_op(OP_TICK, 8'($urandom), 8'($urandom), line);
        end
    endtask

    task automatic wait_drained();
        while (ops_taken != ops_queued || predicted_results.size() != 0) @(posedge i_clk);
    endtask

    // Writes all five registers, only once every queued item has been answered.
    task automatic program_regs(input t_cfg c);
        wait_drained();
        repeat (2) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_SLAVE_ADDRESS;
        i_cfg_data  <= {5'd0, c.slave_address};
        @(posedge i_clk);
        i_cfg_index <= CFG_HOLD_TICKS;
        i_cfg_data  <= {4'd0, c.hold_ticks};
        @(posedge i_clk);
        i_cfg_index <= CFG_ADDR_ACK_WAIT;
        i_cfg_data  <= c.address_ack_wait;
        @(posedge i_clk);
        i_cfg_index <= CFG_BYTE_ACK_WAIT;
        i_cfg_data  <= {4'd0, c.byte_ack_wait};
        @(posedge i_clk);
        i_cfg_index <= CFG_ADDR_RETRIES;
        i_cfg_data  <= {9'd0, c.address_retries};
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        eng_cfg = c;
    endtask

    function automatic t_cfg make_cfg(input int addr, input int hold, input int aack,
                                      input int back, input int retries);
        t_cfg c;
        c.slave_address    = addr[6:0];
        c.hold_ticks       = hold[7:0];
        c.address_ack_wait = aack[11:0];
        c.byte_ack_wait    = back[7:0];
        c.address_retries  = retries[2:0];
        return c;
    endfunction

    initial begin
        int         k;
        int         j;
        int         reps;
        int         nacks;
        int         noise;
        logic [7:0] cnt;

        eng_cfg   = CFG_RESET;
        gen_state = fresh_state();
        chk_state = fresh_state();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Only the address acknowledge wait is shortened; the other four registers keep
        // their reset values for the first transfer.
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_ADDR_ACK_WAIT;
        i_cfg_data  <= 12'd2;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        eng_cfg.address_ack_wait = 12'd2;

        // Ticks while idle do nothing. The buffer is filled to the brink and one load
        // past it is dropped; a short write then sends the first two bytes, with its
        // address refused once and taken on the first repeated start.
        push_op(OP_TICK, 8'h00, 8'h00, 1'b0);
        push_op(OP_TICK, 8'hff, 8'hff, 1'b1);
        load_buffer(BUF_DEPTH + 1);
        run_transfer(OP_WRITE, 8'd2, 1, 0, 0);

        // Random part: short transfers under randomly chosen fast settings, with
        // refused addresses, ignored items and oversized begins mixed in.
        random_work = 0;
        while (random_work < RANDOM_WORK) begin
            k = $urandom_range(0, 2);
            idle_pct = (k == 0) ? 0 : ((k == 1) ? 8 : 25);
            // The closing stretch of the run goes without gaps or stalls.
            if (random_work >= RANDOM_WORK - CALM_WORK) idle_pct = 0;
            program_regs(make_cfg($urandom_range(0, 127), $urandom_range(0, 2),
                                  $urandom_range(0, 3), $urandom_range(0, 2),
                                  $urandom_range(0, 7)));
            reps = $urandom_range(1, 3);
            for (j = 0; j < reps && random_work < RANDOM_WORK; j++) begin
                if (random_work >= RANDOM_WORK - CALM_WORK) idle_pct = 0;
                k     = $urandom_range(0, 19);
                cnt   = ($urandom_range(0, 9) == 0) ? 8'd0 : 8'($urandom_range(1, 4));
                nacks = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 8) : 0;
                noise = ($urandom_range(0, 1) == 0) ? 0 : 10;
                if (k == 0) begin
                    repeat ($urandom_range(1, 3)) begin
                        push_op(OP_TICK, 8'($urandom), 8'($urandom), 1'($urandom));
                    end
                    push_op(t_op'($urandom_range(1, 2)), 8'($urandom_range(129, 255)),
                            8'($urandom), 1'($urandom));
                end else if (k < 10) begin
                    load_buffer($urandom_range(0, 4));
                    run_transfer(OP_WRITE, cnt, nacks, 15, noise);
                end else begin
                    run_transfer(OP_READ, cnt, nacks, 15, noise);
                end
            end
        end

        wait_drained();
        repeat (8) @(posedge i_clk);
        $display("Checked %0d results from %0d items: %0d transfers completed,",
                 results_seen, ops_taken, done_seen);
        $display("%0d gave up on a refused address, %0d bytes received from the target.",
                 nack_seen, bytes_seen);
        if (mismatches == 0 && stray == 0 && predicted_results.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("%0d field mismatches, %0d unpredicted results, %0d predictions unmet",
                     mismatches, stray, predicted_results.size());
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
